// ===== rtl/particle_rotation_update_unit_defines.svh =====
// Assertion macros shared by the particle rotation update RTL.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef PARTICLE_ROTATION_UPDATE_UNIT_DEFINES_SVH
`define PARTICLE_ROTATION_UPDATE_UNIT_DEFINES_SVH

// Same-cycle implication, quiet while reset is asserted.
`define PRU_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, quiet while reset is asserted.
`define PRU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/pru_pkg.sv =====
`timescale 1ns / 1ps
// Types, constants and step functions of the particle rotation update pipeline.
// No dependencies.
package pru_pkg;

    localparam int CX_W     = 35;
    localparam int CZ_W     = 24;
    localparam int DIV_BITS = 16;
    localparam int ATAN_LEN = 20;

    localparam logic [2:0] CFG_MODE  = 3'd0;
    localparam logic [2:0] CFG_START = 3'd1;
    localparam logic [2:0] CFG_END   = 3'd2;
    localparam logic [2:0] CFG_ALIGN = 3'd3;
    localparam logic [2:0] CFG_MIN   = 3'd4;
    localparam logic [2:0] CFG_MAX   = 3'd5;

    localparam int MODE_EN    = 0;
    localparam int MODE_LIFE  = 1;
    localparam int MODE_ALIGN = 2;
    localparam int MODE_LIMIT = 3;

    localparam logic signed [24:0] V_PI       = 25'sd12868;
    localparam logic [15:0]        TWO_PI     = 16'd25736;
    localparam logic [15:0]        PI_M1      = 16'd12867;
    localparam logic [15:0]        WRAP_RECIP = 16'd41721;

    localparam logic signed [CZ_W-1:0] ATAN_TBL [ATAN_LEN] = '{
        24'sd823550, 24'sd486170, 24'sd256879, 24'sd130396, 24'sd65451,
        24'sd32757,  24'sd16383,  24'sd8192,   24'sd4096,   24'sd2048,
        24'sd1024,   24'sd512,    24'sd256,    24'sd128,    24'sd64,
        24'sd32,     24'sd16,     24'sd8,      24'sd4,      24'sd2
    };

    typedef struct packed {
        logic signed [CX_W-1:0] x;
        logic signed [CX_W-1:0] y;
        logic signed [CZ_W-1:0] z;
    } cordic_t;

    typedef struct packed {
        logic [2:0][15:0] ang;
        logic [2:0][15:0] spd;
        logic [15:0]      dt;
        logic [15:0]      life;
        logic [15:0]      rem;
        logic [15:0]      quo;
        logic             full;
        logic [2:0]       pzero;
        cordic_t [2:0]    cor;
    } front_t;

    typedef struct packed {
        logic [2:0][15:0] ang;
        logic [2:0][15:0] spd;
        logic [2:0][15:0] align;
        logic [15:0]      dt;
        logic [14:0]      mult;
    } t1_t;

    typedef struct packed {
        logic [2:0][15:0] ang;
        logic [2:0][15:0] spd;
        logic [15:0]      dt;
        logic [2:0][31:0] p1;
        logic [2:0][31:0] p2;
    } t2_t;

    typedef struct packed {
        logic [2:0][15:0] ang;
        logic [15:0]      dt;
        logic [2:0][34:0] sp;
    } t3_t;

    typedef struct packed {
        logic [2:0][15:0] ang;
        logic [2:0][34:0] ph;
        logic [2:0][32:0] pl;
    } t4_t;

    typedef struct packed {
        logic [2:0][15:0] ang;
        logic [2:0][24:0] v;
    } t5_t;

    typedef struct packed {
        logic [2:0][15:0] res;
        logic [2:0]       wrap;
        logic [2:0]       neg;
        logic [2:0][23:0] u;
        logic [2:0][9:0]  q;
    } t6_t;

    typedef struct packed {
        logic [2:0][15:0] res;
        logic [2:0]       wrap;
        logic [2:0]       neg;
        logic [2:0][15:0] rem;
    } t7_t;

    // Fold the vector into the right half plane before the iterations.
    function automatic cordic_t cordic_pre(logic [15:0] y, logic [15:0] x);
        cordic_t c;
        logic signed [CX_W-1:0] cx;
        logic signed [CX_W-1:0] cy;
        cx = {{(CX_W-32){x[15]}}, x, 16'h0000};
        cy = {{(CX_W-32){y[15]}}, y, 16'h0000};
        c.x = cx;
        c.y = cy;
        c.z = '0;
        if (cx < 0)
        begin
            if (cy >= 0)
            begin
                c.x = cy;
                c.y = -cx;
                c.z = ATAN_TBL[0] <<< 1;
            end
            else
            begin
                c.x = -cy;
                c.y = cx;
                c.z = -(ATAN_TBL[0] <<< 1);
            end
        end
        return c;
    endfunction

    function automatic cordic_t cordic_iter(cordic_t c, int i);
        cordic_t n;
        logic signed [CX_W-1:0] dx;
        logic signed [CX_W-1:0] dy;
        dx = c.y >>> i;
        dy = c.x >>> i;
        if (c.y > 0)
        begin
            n.x = c.x + dx;
            n.y = c.y - dy;
            n.z = c.z + ATAN_TBL[i];
        end
        else
        begin
            n.x = c.x - dx;
            n.y = c.y + dy;
            n.z = c.z - ATAN_TBL[i];
        end
        return n;
    endfunction

    // One restoring quotient bit of age * 2^16 / life.
    function automatic front_t div_step(front_t s);
        front_t n;
        logic [16:0] t;
        n = s;
        t = {s.rem, 1'b0};
        if (t >= {1'b0, s.life})
        begin
            n.rem = 16'(t - {1'b0, s.life});
            n.quo = {s.quo[14:0], 1'b1};
        end
        else
        begin
            n.rem = t[15:0];
            n.quo = {s.quo[14:0], 1'b0};
        end
        return n;
    endfunction

endpackage

// ===== rtl/particle_rotation_update_unit.sv =====
`timescale 1ns / 1ps
// Particle rotation update: one particle a cycle through a stalling pipeline.
// Depends on pru_pkg and particle_rotation_update_unit_defines.svh.
//
// Input channel: in_valid / in_stall with the current angles, spin speeds,
// velocity, age, life span and time step of one particle. Output channel:
// out_valid / out_stall with the three updated angles. An item moves on at an
// edge where valid is high and stall is low.
// The front stages run the 16-bit lifetime divider and the three atan2 CORDIC
// units side by side, at most one quotient bit and one rotation per stage;
// eight more stages blend the multiplier, form the speeds, multiply by the
// step and wrap or clamp.
// Throughput is one item per cycle while out_stall is low. Each stage holds its
// item only while the stage after it is full and holding, so empty slots close
// up under a stall and in_stall rises only once every stage is occupied.
// Reset empties the pipeline and loads the register defaults: enabled, unit
// multipliers and alignment weight, zero limits. Write configuration through
// cfg_we / cfg_index / cfg_data only while no item is in flight.
module particle_rotation_update_unit
    import pru_pkg::*;
#(
    parameter int CORDIC_STEPS = 14
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] angle_x,
    input  logic [15:0] angle_y,
    input  logic [15:0] angle_z,
    input  logic [15:0] speed_x,
    input  logic [15:0] speed_y,
    input  logic [15:0] speed_z,
    input  logic [15:0] vel_x,
    input  logic [15:0] vel_y,
    input  logic [15:0] vel_z,
    input  logic [15:0] age,
    input  logic [15:0] life_span,
    input  logic [15:0] time_step,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] new_angle_x,
    output logic [15:0] new_angle_y,
    output logic [15:0] new_angle_z,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [47:0] cfg_data
);

`include "particle_rotation_update_unit_defines.svh"

    localparam int MID  = (CORDIC_STEPS > DIV_BITS) ? CORDIC_STEPS : DIV_BITS;
    localparam int NSTG = MID + 9;

    logic [3:0]  mode_reg;
    logic [14:0] start_reg;
    logic [14:0] end_reg;
    logic [14:0] strength_reg;
    logic [47:0] min_reg;
    logic [47:0] max_reg;

    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] adv;

    front_t pipe_reg [0:MID];
    t1_t    t1_reg;
    t2_t    t2_reg;
    t3_t    t3_reg;
    t4_t    t4_reg;
    t5_t    t5_reg;
    t6_t    t6_reg;
    t7_t    t7_reg;
    logic [2:0][15:0] out_reg;

    t1_t    t1_next;
    t2_t    t2_next;
    t3_t    t3_next;
    t4_t    t4_next;
    t5_t    t5_next;
    t6_t    t6_next;
    t7_t    t7_next;
    logic [2:0][15:0] out_next;
    front_t front_next;

    logic in_acc;
    logic out_acc;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= 4'd1;
            start_reg    <= 15'd4096;
            end_reg      <= 15'd4096;
            strength_reg <= 15'd4096;
            min_reg      <= '0;
            max_reg      <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MODE:  mode_reg     <= cfg_data[3:0];
                CFG_START: start_reg    <= cfg_data[14:0];
                CFG_END:   end_reg      <= cfg_data[14:0];
                CFG_ALIGN: strength_reg <= cfg_data[14:0];
                CFG_MIN:   min_reg      <= cfg_data;
                CFG_MAX:   max_reg      <= cfg_data;
                default:   ;
            endcase
        end
    end

    // Stage advance: a stage loads when it is empty or its successor moves.
    always_comb
    begin
        adv[NSTG-1] = !vld_reg[NSTG-1] || !out_stall;
        for (int k = NSTG - 2; k >= 0; k--)
            adv[k] = !vld_reg[k] || adv[k+1];
    end

    assign in_stall  = !adv[0];
    assign out_valid = vld_reg[NSTG-1];
    assign in_acc    = in_valid && !in_stall;
    assign out_acc   = out_valid && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            if (adv[0])
                vld_reg[0] <= in_valid;
            for (int k = 1; k < NSTG; k++)
                if (adv[k])
                    vld_reg[k] <= vld_reg[k-1];
        end
    end

    // Stage 0: capture, fold the CORDIC vectors, seed the divider
    always_comb
    begin
        front_next.ang   = {angle_z, angle_y, angle_x};
        front_next.spd   = {speed_z, speed_y, speed_x};
        front_next.dt    = time_step;
        front_next.life  = life_span;
        front_next.rem   = age;
        front_next.quo   = '0;
        front_next.full  = (life_span == 16'd0) || (age >= life_span);
        front_next.pzero = {(vel_y == 16'd0) && (vel_x == 16'd0),
                            (vel_x == 16'd0) && (vel_z == 16'd0),
                            (vel_y == 16'd0) && (vel_z == 16'd0)};
        front_next.cor[0] = cordic_pre(vel_y, vel_z);
        front_next.cor[1] = cordic_pre(vel_x, vel_z);
        front_next.cor[2] = cordic_pre(vel_y, vel_x);
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
            pipe_reg[0] <= front_next;
    end

    // Middle stages: at most one quotient bit and one rotation per axis each
    for (genvar k = 1; k <= MID; k++)
    begin : g_mid
        front_t div_s;
        front_t cor_s;

        if (k <= DIV_BITS)
        begin : g_div
            always_comb div_s = div_step(pipe_reg[k-1]);
        end
        else
        begin : g_nodiv
            assign div_s = pipe_reg[k-1];
        end

        if (k - 1 < CORDIC_STEPS)
        begin : g_cor
            always_comb
            begin
                cor_s = div_s;
                for (int a = 0; a < 3; a++)
                    cor_s.cor[a] = cordic_iter(div_s.cor[a], k - 1);
            end
        end
        else
        begin : g_nocor
            assign cor_s = div_s;
        end

        always_ff @(posedge clk)
        begin
            if (adv[k])
                pipe_reg[k] <= cor_s;
        end
    end

    // T1: blended multiplier and rounded alignment angles
    always_comb
    begin
        front_t s;
        logic [16:0]        r;
        logic signed [15:0] diff;
        logic signed [33:0] prod;
        logic signed [17:0] msum;
        logic signed [CZ_W-1:0] zr;
        s    = pipe_reg[MID];
        r    = s.full ? 17'h10000 : {1'b0, s.quo};
        diff = $signed({1'b0, end_reg}) - $signed({1'b0, start_reg});
        prod = diff * $signed({1'b0, r});
        msum = $signed({3'b000, start_reg}) + prod[33:16];
        t1_next.ang  = s.ang;
        t1_next.spd  = s.spd;
        t1_next.dt   = s.dt;
        t1_next.mult = msum[14:0];
        for (int a = 0; a < 3; a++)
        begin
            zr = s.cor[a].z + 24'sd128;
            t1_next.align[a] = (mode_reg[MODE_ALIGN] && !s.pzero[a]) ? zr[23:8] : 16'd0;
        end
    end

    // T2: speed times multiplier, alignment times weight
    always_comb
    begin
        t2_next.ang = t1_reg.ang;
        t2_next.spd = t1_reg.spd;
        t2_next.dt  = t1_reg.dt;
        for (int a = 0; a < 3; a++)
        begin
            t2_next.p1[a] = $signed(t1_reg.spd[a]) * $signed({1'b0, t1_reg.mult});
            t2_next.p2[a] = $signed(t1_reg.align[a]) * $signed({1'b0, strength_reg});
        end
    end

    // T3: effective speed in Q.24
    always_comb
    begin
        logic [34:0] base;
        t3_next.ang = t2_reg.ang;
        t3_next.dt  = t2_reg.dt;
        for (int a = 0; a < 3; a++)
        begin
            base = mode_reg[MODE_LIFE] ? {t2_reg.p1[a][31], t2_reg.p1[a], 2'b00}
                                       : {{5{t2_reg.spd[a][15]}}, t2_reg.spd[a], 14'd0};
            t3_next.sp[a] = base + {{3{t2_reg.p2[a][31]}}, t2_reg.p2[a]};
        end
    end

    // T4: speed times step, split into two partial products
    always_comb
    begin
        t4_next.ang = t3_reg.ang;
        for (int a = 0; a < 3; a++)
        begin
            t4_next.ph[a] = $signed(t3_reg.sp[a][34:17]) * $signed({1'b0, t3_reg.dt});
            t4_next.pl[a] = t3_reg.sp[a][16:0] * t3_reg.dt;
        end
    end

    // T5: merge partials, floor to Q3.12, add to the angle
    always_comb
    begin
        logic [51:0] sum;
        logic [23:0] stp;
        t5_next.ang = t4_reg.ang;
        for (int a = 0; a < 3; a++)
        begin
            sum = {t4_reg.ph[a], 17'd0} + {19'd0, t4_reg.pl[a]};
            stp = sum[51:28];
            t5_next.v[a] = {{9{t4_reg.ang[a][15]}}, t4_reg.ang[a]} + {stp[23], stp};
        end
    end

    // T6: clamp or pass; for wrap, estimate the turn count by reciprocal
    always_comb
    begin
        logic signed [24:0] v;
        logic signed [24:0] lo;
        logic signed [24:0] hi;
        logic [24:0]        uw;
        logic [39:0]        qp;
        for (int a = 0; a < 3; a++)
        begin
            v  = $signed(t5_reg.v[a]);
            lo = $signed({{9{min_reg[16*a+15]}}, min_reg[16*a +: 16]});
            hi = $signed({{9{max_reg[16*a+15]}}, max_reg[16*a +: 16]});
            t6_next.res[a]  = v[15:0];
            t6_next.wrap[a] = 1'b0;
            t6_next.neg[a]  = 1'b0;
            uw = '0;
            if (!mode_reg[MODE_EN])
                t6_next.res[a] = t5_reg.ang[a];
            else if (mode_reg[MODE_LIMIT])
            begin
                priority if (v < lo)
                    t6_next.res[a] = lo[15:0];
                else if (v > hi)
                    t6_next.res[a] = hi[15:0];
            end
            else if (v > V_PI)
            begin
                t6_next.wrap[a] = 1'b1;
                uw = v - V_PI - 25'sd1;
            end
            else if (v < -V_PI)
            begin
                t6_next.wrap[a] = 1'b1;
                t6_next.neg[a]  = 1'b1;
                uw = ~v - V_PI;
            end
            t6_next.u[a] = uw[23:0];
            qp = uw[23:0] * WRAP_RECIP;
            t6_next.q[a] = qp[39:30];
        end
    end

    // T7: remainder against the estimated turn count
    always_comb
    begin
        logic [23:0] qm;
        logic [23:0] r24;
        t7_next.res  = t6_reg.res;
        t7_next.wrap = t6_reg.wrap;
        t7_next.neg  = t6_reg.neg;
        for (int a = 0; a < 3; a++)
        begin
            qm  = {14'd0, t6_reg.q[a]} * {8'd0, TWO_PI};
            r24 = t6_reg.u[a] - qm;
            t7_next.rem[a] = r24[15:0];
        end
    end

    // T8: correct the estimate by one turn and place into [-pi, pi]
    always_comb
    begin
        logic [15:0] r2;
        for (int a = 0; a < 3; a++)
        begin
            r2 = (t7_reg.rem[a] >= TWO_PI) ? t7_reg.rem[a] - TWO_PI : t7_reg.rem[a];
            if (!t7_reg.wrap[a])
                out_next[a] = t7_reg.res[a];
            else if (t7_reg.neg[a])
                out_next[a] = PI_M1 - r2;
            else
                out_next[a] = r2 - PI_M1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[MID+1])
            t1_reg <= t1_next;
        if (adv[MID+2])
            t2_reg <= t2_next;
        if (adv[MID+3])
            t3_reg <= t3_next;
        if (adv[MID+4])
            t4_reg <= t4_next;
        if (adv[MID+5])
            t5_reg <= t5_next;
        if (adv[MID+6])
            t6_reg <= t6_next;
        if (adv[MID+7])
            t7_reg <= t7_next;
        if (adv[MID+8])
            out_reg <= out_next;
    end

    assign new_angle_x = out_reg[0];
    assign new_angle_y = out_reg[1];
    assign new_angle_z = out_reg[2];

    `PRU_ASSERT(a_empty_no_stall, !out_valid, !in_stall, "stall raised with empty output")
    `PRU_ASSERT(a_occupancy, $past(rst_n), $countones(vld_reg) == $past($countones(vld_reg)) + int'($past(in_acc)) - int'($past(out_acc)), "pipeline lost or invented an item")
    `PRU_ASSERT(a_div_rem, vld_reg[MID] && !pipe_reg[MID].full, pipe_reg[MID].rem < pipe_reg[MID].life, "divider remainder out of range")
    `PRU_ASSERT_NEXT(a_hold_last, out_valid && out_stall, out_valid && $stable(out_reg), "stalled result not held")

endmodule
